[rtl/apn_pkg.sv]
`default_nettype none

package apn_pkg;

    // Field widths of the two channels and the configuration register.
    localparam int SAMPLE_W    = 32;
    localparam int NORM_W      = 16;
    localparam int INDEX_W     = 12;
    localparam int OUT_LEN_W   = 13;

    // The full-scale factor 32767 is 2^QUOT_W - 1, so the quotient needs QUOT_W bits.
    localparam int QUOT_W      = 15;

    // Default store depth and the reset value of out_length.
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam logic [OUT_LEN_W-1:0] OUT_LEN_RESET = 13'd4096;

    // Configuration register indexes.
    localparam int REG_OUT_LENGTH = 0;

    // Item kinds on the input channel.
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // Result status codes.
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_EMPTY = 1'b1;

    // Result of the serial divider towards the control logic.
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

endpackage

`default_nettype wire

[rtl/apn_in_if.sv]
`default_nettype none

interface apn_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] sample;
    logic        end_of_scan;

    modport source (output valid, output kind, output sample, output end_of_scan,
                    input ready);
    modport sink   (input valid, input kind, input sample, input end_of_scan,
                    output ready);
endinterface

`default_nettype wire

[rtl/apn_out_if.sv]
`default_nettype none

interface apn_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] norm_value;
    logic        [11:0] out_index;
    logic               final_out;
    logic               status;

    modport source (output valid, output norm_value, output out_index, output final_out,
                    output status, input ready);
    modport sink   (input valid, input norm_value, input out_index, input final_out,
                    input status, output ready);
endinterface

`default_nettype wire

[rtl/apn_store.sv]
`default_nettype none

module apn_store #(
    parameter int DEPTH = apn_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  wire logic [apn_pkg::SAMPLE_W-1:0] i_wdata,
    input  wire logic                         i_re,
    input  wire logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic      [apn_pkg::SAMPLE_W-1:0] o_rdata
);
    import apn_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];

    // Single write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/apn_divider.sv]
`default_nettype none

module apn_divider (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [apn_pkg::SAMPLE_W-1:0] i_mag,
    input  wire logic [apn_pkg::SAMPLE_W-1:0] i_div,
    output apn_pkg::t_div_res                 o_res
);
    import apn_pkg::*;

    localparam int PW = SAMPLE_W + QUOT_W;
    localparam int CW = $clog2(QUOT_W + 1);

    logic [SAMPLE_W-1:0] r_rem,  n_rem;
    logic [QUOT_W-1:0]   r_low,  n_low;
    logic [QUOT_W-1:0]   r_quot, n_quot;
    logic [SAMPLE_W-1:0] r_div,  n_div;
    logic [CW-1:0]       r_cnt,  n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;

    logic [PW-1:0]       prod;
    logic [SAMPLE_W:0]   trial;
    logic [SAMPLE_W:0]   diff;
    logic                ge;

    // The dividend mag * 32767 is formed as (mag << 15) - mag. Its upper part is below
    // the divisor because mag never exceeds it, so QUOT_W restoring steps suffice.
    assign prod  = {i_mag, {QUOT_W{1'b0}}} - {{QUOT_W{1'b0}}, i_mag};
    assign trial = {r_rem, r_low[QUOT_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    // One quotient bit per cycle.
    always_comb begin
        n_rem  = r_rem;
        n_low  = r_low;
        n_quot = r_quot;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = prod[PW-1:QUOT_W];
            n_low  = prod[QUOT_W-1:0];
            n_div  = i_div;
            n_quot = '0;
            n_cnt  = CW'(QUOT_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            n_low  = {r_low[QUOT_W-2:0], 1'b0};
            n_quot = {r_quot[QUOT_W-2:0], ge};
            n_cnt  = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_low  <= n_low;
        r_quot <= n_quot;
        r_div  <= n_div;
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

endmodule

`default_nettype wire

[rtl/audio_peak_normalizer_unit.sv]
// Peak normaliser for signed 32-bit audio, giving 16-bit output.
// Input channel: each request carries kind, sample and end_of_scan. A load (kind 0)
// updates the running peak magnitude and stores the sample while the store has room;
// a load flagged end_of_scan closes the scan. A load after a closed scan starts anew.
// A drain request (kind 1) returns one result on the output channel: the next stored
// sample scaled by 32767 / peak, truncated towards zero, with its index and a final
// flag, or status 1 when the scan is open or the run is drained.
// Loads are taken and applied in idle. A drain request passes through the store read,
// the bit-serial restoring divider (one quotient bit per cycle), its registered done
// flag, the hand-over to the output register and the return to idle; a zero peak skips
// the divider. An empty response goes straight to the hand-over.
// Only one request is in flight at a time; input ready is high while the control
// logic is idle, also while a finished result waits in the output register.
// When the receiver stalls, a further result waits in the holding stage until the
// output register frees, and the input stays blocked meanwhile.
// Reset (synchronous, active low) clears peak, counts, read pointer and scan flag,
// and sets out_length to 4096. The sample store is not cleared; only written
// entries are ever read. out_length is written through the APB port at address 0.
`default_nettype none

module audio_peak_normalizer_unit #(
    parameter int MAX_SAMPLES = apn_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    apn_in_if.sink           i_in,
    apn_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import apn_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int LW = (CW > OUT_LEN_W) ? CW : OUT_LEN_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIV  = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [OUT_LEN_W-1:0]  r_out_length;
    logic [SAMPLE_W-1:0]   r_peak, n_peak;
    logic [CW-1:0]         r_loaded, n_loaded;
    logic [CW-1:0]         r_rp, n_rp;
    logic                  r_scan_done, n_scan_done;
    logic                  r_neg, n_neg;

    logic signed [NORM_W-1:0] r_res_value, n_res_value;
    logic [INDEX_W-1:0]       r_res_index, n_res_index;
    logic                     r_res_final, n_res_final;
    logic                     r_res_status, n_res_status;

    logic                     r_out_valid, n_out_valid;
    logic signed [NORM_W-1:0] r_out_value, n_out_value;
    logic [INDEX_W-1:0]       r_out_index, n_out_index;
    logic                     r_out_final, n_out_final;
    logic                     r_out_status, n_out_status;

    logic                  accept;
    logic                  cfg_write;
    logic [SAMPLE_W-1:0]   base_peak;
    logic [CW-1:0]         base_loaded;
    logic [SAMPLE_W-1:0]   load_mag;
    logic [SAMPLE_W-1:0]   rd_mag;
    logic [LW-1:0]         run;
    logic                  req_empty;
    logic                  st_we;
    logic                  st_re;
    logic [SAMPLE_W-1:0]   st_rdata;
    logic                  div_start;
    t_div_res              div_res;
    logic [NORM_W-1:0]     quot_ext;

    // Handshakes.
    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && (paddr[2] == 1'(REG_OUT_LENGTH));
    assign prdata     = (paddr[2] == 1'(REG_OUT_LENGTH)) ? 32'(r_out_length) : 32'd0;

    // A load after a closed scan starts from cleared state.
    assign base_peak   = r_scan_done ? '0 : r_peak;
    assign base_loaded = r_scan_done ? '0 : r_loaded;
    assign load_mag    = i_in.sample[SAMPLE_W-1] ? (SAMPLE_W'(0) - i_in.sample)
                                                 : i_in.sample;
    assign st_we       = accept && (i_in.kind == KIND_LOAD)
                         && (base_loaded < CW'(MAX_SAMPLES));

    // Run length and the empty-response condition for a drain request.
    assign run       = (LW'(r_out_length) < LW'(r_loaded)) ? LW'(r_out_length)
                                                           : LW'(r_loaded);
    assign req_empty = !r_scan_done || (LW'(r_rp) >= run);
    assign st_re     = accept && (i_in.kind == KIND_REQUEST) && !req_empty;

    assign rd_mag    = st_rdata[SAMPLE_W-1] ? (SAMPLE_W'(0) - st_rdata) : st_rdata;
    assign quot_ext  = NORM_W'(div_res.quot);

    apn_store #(
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (base_loaded[AW-1:0]),
        .i_wdata (i_in.sample),
        .i_re    (st_re),
        .i_raddr (r_rp[AW-1:0]),
        .o_rdata (st_rdata)
    );

    apn_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (rd_mag),
        .i_div   (r_peak),
        .o_res   (div_res)
    );

    // Control sequencing and result staging.
    always_comb begin
        n_state      = r_state;
        n_peak       = r_peak;
        n_loaded     = r_loaded;
        n_rp         = r_rp;
        n_scan_done  = r_scan_done;
        n_neg        = r_neg;
        n_res_value  = r_res_value;
        n_res_index  = r_res_index;
        n_res_final  = r_res_final;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_index  = r_out_index;
        n_out_final  = r_out_final;
        n_out_status = r_out_status;
        div_start    = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.kind == KIND_LOAD) begin
                        n_peak      = (load_mag > base_peak) ? load_mag : base_peak;
                        n_loaded    = (base_loaded < CW'(MAX_SAMPLES))
                                      ? base_loaded + CW'(1) : base_loaded;
                        n_rp        = r_scan_done ? '0 : r_rp;
                        n_scan_done = i_in.end_of_scan;
                    end else if (req_empty) begin
                        n_res_value  = '0;
                        n_res_index  = '0;
                        n_res_final  = 1'b0;
                        n_res_status = ST_EMPTY;
                        n_state      = S_HOLD;
                    end else begin
                        n_res_index  = INDEX_W'(r_rp);
                        n_res_final  = ((LW'(r_rp) + LW'(1)) == run);
                        n_res_status = ST_OK;
                        n_rp         = r_rp + CW'(1);
                        n_state      = S_READ;
                    end
                end
            end
            S_READ: begin
                if (r_peak == '0) begin
                    n_res_value = '0;
                    n_state     = S_HOLD;
                end else begin
                    div_start = 1'b1;
                    n_neg     = st_rdata[SAMPLE_W-1];
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    n_res_value = r_neg ? (NORM_W'(0) - quot_ext) : quot_ext;
                    n_state     = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_index  = r_res_index;
                    n_out_final  = r_res_final;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_length <= OUT_LEN_RESET;
            r_peak       <= '0;
            r_loaded     <= '0;
            r_rp         <= '0;
            r_scan_done  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_peak       <= n_peak;
            r_loaded     <= n_loaded;
            r_rp         <= n_rp;
            r_scan_done  <= n_scan_done;
            r_out_valid  <= n_out_valid;
            if (cfg_write) begin
                r_out_length <= pwdata[OUT_LEN_W-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_neg        <= n_neg;
        r_res_value  <= n_res_value;
        r_res_index  <= n_res_index;
        r_res_final  <= n_res_final;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_index  <= n_out_index;
        r_out_final  <= n_out_final;
        r_out_status <= n_out_status;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.norm_value = r_out_value;
    assign o_out.out_index  = r_out_index;
    assign o_out.final_out  = r_out_final;
    assign o_out.status     = r_out_status;

endmodule

`default_nettype wire

[sim/tb_audio_peak_normalizer_unit.sv]
`timescale 1ns / 100ps

module tb_audio_peak_normalizer_unit;
    import apn_pkg::*;

    localparam int     STORE_DEPTH   = MAX_SAMPLES_DEF;
    localparam int     RANDOM_ITEMS  = 800;
    localparam int     CYCLE_LIMIT   = 3_000_000;
    localparam int     SETTLE_CYCLES = 32;
    localparam int     TAIL_CYCLES   = 64;
    localparam int     MAX_REPORTS   = 10;
    localparam int     DIR_ROWS      = 25;
    localparam longint FULL_SCALE    = 32767;

    // One normalised result as it leaves the block.
    typedef struct packed {
        logic signed [15:0] value;
        logic [11:0]        index;
        logic               last_flag;
        logic               status;
    } t_norm_res;

    // One row of the directed table; typed rows carry a result read off by hand.
    typedef struct {
        logic        kind;
        logic [31:0] smp;
        logic        eos;
        bit          typed;
        t_norm_res   res;
    } t_dir_row;

    localparam t_norm_res EMPTY_RES = '{16'sd0, 12'd0, 1'b0, ST_EMPTY};

    // Directed part: empty responses, full-scale extremes, zero peak and a lone sample.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{KIND_REQUEST, 32'h0000_0000, 1'b0, 1'b1, EMPTY_RES},
        '{KIND_LOAD,    32'h7FFF_FFFF, 1'b0, 1'b0, EMPTY_RES},
        '{KIND_REQUEST, 32'hDEAD_BEEF, 1'b1, 1'b1, EMPTY_RES},
        '{KIND_LOAD,    32'h8000_0000, 1'b0, 1'b0, EMPTY_RES},
        '{KIND_LOAD,    32'h0000_0000, 1'b0, 1'b0, EMPTY_RES},
        '{KIND_LOAD,    32'h0000_0001, 1'b1, 1'b0, EMPTY_RES},
        '{KIND_REQUEST, 32'h0000_0000, 1'b0, 1'b0, EMPTY_RES},
        '{KIND_REQUEST, 32'h0000_0000, 1'b0, 1'b1, '{-16'sd32767, 12'd1, 1'b0, ST_OK}},
        '{KIND_REQUEST, 32'h0000_0000, 1'b0, 1'b1, '{16'sd0, 12'd2, 1'b0, ST_OK}},
        '{KIND_REQUEST, 32'h0000_0000, 1'b0, 1'b0, EMPTY_RES},
        '{KIND_REQUEST, 32'h0000_0000, 1'b0, 1'b1, EMPTY_RES},
        '{KIND_LOAD,    32'h0000_0000, 1'b0, 1'b0, EMPTY_RES},
        '{KIND_LOAD,    32'h0000_0000, 1'b1, 1'b0, EMPTY_RES},
        '{KIND_REQUEST, 32'hFFFF_FFFF, 1'b0, 1'b1, '{16'sd0, 12'd0, 1'b0, ST_OK}},
        '{KIND_REQUEST, 32'h0000_0000, 1'b1, 1'b1, '{16'sd0, 12'd1, 1'b1, ST_OK}},
        '{KIND_REQUEST, 32'h0000_0000, 1'b0, 1'b1, EMPTY_RES},
        '{KIND_LOAD,    32'h0000_1234, 1'b1, 1'b0, EMPTY_RES},
        '{KIND_REQUEST, 32'h0000_0000, 1'b0, 1'b1, '{16'sd32767, 12'd0, 1'b1, ST_OK}},
        '{KIND_LOAD,    32'hFFFF_EDCC, 1'b0, 1'b0, EMPTY_RES},
        '{KIND_LOAD,    32'h0000_091A, 1'b1, 1'b0, EMPTY_RES},
        '{KIND_REQUEST, 32'h0000_0000, 1'b0, 1'b1, '{-16'sd32767, 12'd0, 1'b0, ST_OK}},
        '{KIND_REQUEST, 32'h0000_0000, 1'b0, 1'b0, EMPTY_RES},
        '{KIND_REQUEST, 32'h0000_0000, 1'b0, 1'b1, EMPTY_RES},
        '{KIND_LOAD,    32'hFFFF_FFFF, 1'b1, 1'b0, EMPTY_RES},
        '{KIND_REQUEST, 32'h0000_0000, 1'b0, 1'b1, '{-16'sd32767, 12'd0, 1'b1, ST_OK}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    apn_in_if  in_bus ();
    apn_out_if out_bus ();

    audio_peak_normalizer_unit #(
        .MAX_SAMPLES (STORE_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Own copy of the normaliser state and its register.
    logic [31:0] model_store [STORE_DEPTH];
    logic [31:0] model_peak;
    int unsigned model_count;
    int unsigned model_rdptr;
    bit          model_closed;
    logic [12:0] model_len;

    t_norm_res   expected_norm_q [$];
    logic        row_typed;
    t_norm_res   row_result;
    bit          bursts_on;
    int          stall_left;
    int          cycle_count;
    int          err_count;
    int          sent_items;
    int          results_seen;
    int          reg_writes;
    int unsigned len_lo;
    int unsigned len_hi;

    // Clock with a period of 8 ns.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog on the total number of cycles.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still awaited.",
                 cycle_count, expected_norm_q.size());
        $display("tb_audio_peak_normalizer_unit: done, errors");
        $finish;
    end

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endfunction

    // Works out what one accepted request does to the state, and its result if any.
    function automatic void predict_norm(input logic k, input logic [31:0] s, input logic e,
                                         output bit gives, output t_norm_res r);
        logic [31:0] mag;
        int unsigned run;
        longint      num;
        longint      quot;
        gives = 1'b0;
        r     = EMPTY_RES;
        if (k == KIND_LOAD) begin
            // A load after a closed scan opens a fresh one.
            if (model_closed) begin
                model_peak   = '0;
                model_count  = 0;
                model_rdptr  = 0;
                model_closed = 1'b0;
            end
            mag = s[31] ? (32'd0 - s) : s;
            if (mag > model_peak) begin
                model_peak = mag;
            end
            if (model_count < STORE_DEPTH) begin
                model_store[model_count] = s;
                model_count++;
            end
            if (e) begin
                model_closed = 1'b1;
            end
        end else begin
            gives = 1'b1;
            run   = (model_len < model_count) ? model_len : model_count;
            if (model_closed && model_rdptr < run) begin
                num  = longint'(signed'(model_store[model_rdptr])) * FULL_SCALE;
                quot = (model_peak == '0) ? 64'sd0 : num / longint'({32'd0, model_peak});
                r.value     = quot[15:0];
                r.index     = model_rdptr[11:0];
                r.last_flag = (model_rdptr + 1 == run);
                r.status    = ST_OK;
                model_rdptr++;
            end
        end
    endfunction

    // Receiver: ready drops in random bursts while idling is enabled.
    always @(negedge i_clk) begin
        if (!bursts_on) begin
            out_bus.ready <= 1'b1;
        end else if (stall_left != 0) begin
            out_bus.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if ($urandom_range(0, 23) == 0) begin
            out_bus.ready <= 1'b0;
            stall_left    <= $urandom_range(0, 17);
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    // Checks each result against the oldest expectation, then predicts from each request.
    always @(posedge i_clk) begin : monitor
        t_norm_res got;
        t_norm_res want;
        t_norm_res pred;
        bit        gives;
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                got.value     = out_bus.norm_value;
                got.index     = out_bus.out_index;
                got.last_flag = out_bus.final_out;
                got.status    = out_bus.status;
                results_seen++;
                if (expected_norm_q.size() == 0) begin
                    note_error($sformatf("result with nothing awaited: value %0d index %0d",
                                         $signed(got.value), got.index));
                end else begin
                    want = expected_norm_q.pop_front();
                    if (got.value !== want.value || got.index !== want.index ||
                        got.last_flag !== want.last_flag || got.status !== want.status) begin
                        note_error({$sformatf("result %0d: expected value %0d index %0d ",
                                              results_seen, $signed(want.value), want.index),
                                    $sformatf("last %0b status %0b, ",
                                              want.last_flag, want.status),
                                    $sformatf("got value %0d index %0d last %0b status %0b",
                                              $signed(got.value), got.index, got.last_flag,
                                              got.status)});
                    end
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                predict_norm(in_bus.kind, in_bus.sample, in_bus.end_of_scan, gives, pred);
                if (gives) begin
                    expected_norm_q.push_back(row_typed ? row_result : pred);
                end
            end
        end
    end

    // Offers one request on the input channel and waits until it is taken.
    task automatic push_item(input logic k, input logic [31:0] s, input logic e,
                             input bit typed, input t_norm_res res);
        @(negedge i_clk);
        if (bursts_on && $urandom_range(0, 9) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.kind        <= k;
        in_bus.sample      <= s;
        in_bus.end_of_scan <= e;
        row_typed          <= typed;
        row_result         <= res;
        do @(posedge i_clk); while (!in_bus.ready);
        sent_items++;
    endtask

    // Stops the sender and waits until every awaited result has arrived.
    task automatic wait_idle();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (expected_norm_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes out_length over APB once the block is idle, then reads it back.
    task automatic write_out_length(input int unsigned len);
        wait_idle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_OUT_LENGTH);
        pwdata  <= 32'(len);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        model_len = len[12:0];
        reg_writes++;
        if (len < len_lo) len_lo = len;
        if (len > len_hi) len_hi = len;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[12:0] !== len[12:0]) begin
            note_error($sformatf("out_length read back as %0d, written %0d",
                                 prdata[12:0], len));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random sample: full range, small values, extremes or a random magnitude.
    function automatic logic [31:0] pick_sample();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = 32'($urandom_range(0, 2000)) - 32'd1000;
            2: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h8000_0001;
                    3:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: begin
                v = $urandom >> $urandom_range(1, 30);
                if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
            end
        endcase
        return v;
    endfunction

    // One scan of random samples with stray requests, then a full or cut-short drain.
    task automatic scan_and_drain(input int unsigned len);
        int unsigned n;
        int unsigned run;
        int unsigned reqs;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                push_item(KIND_REQUEST, $urandom, 1'($urandom), 1'b0, EMPTY_RES);
            end
            push_item(KIND_LOAD, pick_sample(), (i == n - 1), 1'b0, EMPTY_RES);
        end
        run = (len < n) ? len : n;
        if ($urandom_range(0, 5) == 0) begin
            reqs = $urandom_range(0, run - 1);
        end else begin
            reqs = run + $urandom_range(0, 2);
        end
        for (int unsigned i = 0; i < reqs; i++) begin
            push_item(KIND_REQUEST, $urandom, 1'($urandom), 1'b0, EMPTY_RES);
        end
        if ($urandom_range(0, 7) == 0) begin
            wait_idle();
        end
    endtask

    initial begin : stimulus
        int          dir_sent;
        int unsigned len;
        // Known values on every input from time zero.
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_bus.valid       = 1'b0;
        in_bus.kind        = KIND_LOAD;
        in_bus.sample      = '0;
        in_bus.end_of_scan = 1'b0;
        out_bus.ready      = 1'b0;
        row_typed          = 1'b0;
        row_result         = EMPTY_RES;
        bursts_on          = 1'b1;
        stall_left         = 0;
        err_count          = 0;
        sent_items         = 0;
        results_seen       = 0;
        reg_writes         = 0;
        len_lo             = OUT_LEN_RESET;
        len_hi             = OUT_LEN_RESET;
        model_peak         = '0;
        model_count        = 0;
        model_rdptr        = 0;
        model_closed       = 1'b0;
        model_len          = OUT_LEN_RESET;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, run with the reset value of out_length.
        for (int r = 0; r < DIR_ROWS; r++) begin
            push_item(dir_rows[r].kind, dir_rows[r].smp, dir_rows[r].eos,
                      dir_rows[r].typed, dir_rows[r].res);
        end
        dir_sent = sent_items;

        // Random scans under a range of out_length settings.
        write_out_length(1);
        scan_and_drain(1);
        while (sent_items - dir_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       len = 1;
                1:       len = STORE_DEPTH;
                2, 3:    len = $urandom_range(1, 16);
                4:       len = $urandom_range(1, 64);
                default: len = $urandom_range(1, STORE_DEPTH);
            endcase
            write_out_length(len);
            repeat ($urandom_range(2, 5)) scan_and_drain(len);
        end

        // Closing stretch with both sides running flat out.
        write_out_length($urandom_range(1, 32));
        bursts_on = 1'b0;
        repeat (3) scan_and_drain(model_len);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_norm_q.size() != 0) begin
            note_error($sformatf("%0d results never arrived", expected_norm_q.size()));
        end

        $display("Sent %0d requests (%0d random), checked %0d results, %0d register writes.",
                 sent_items, sent_items - dir_sent, results_seen, reg_writes);
        $display("out_length spanned %0d to %0d, with early, stray and cut-short drains.",
                 len_lo, len_hi);
        if (err_count == 0) begin
            $display("tb_audio_peak_normalizer_unit: done, clean");
        end else begin
            $display("tb_audio_peak_normalizer_unit: done, errors");
        end
        $finish;
    end

endmodule
